/* src/rfc5424_timestamp_recognizer_top_defines.svh */
// Assertion macros used by the checker file of the timestamp recognizer.
`ifndef RFC5424_TIMESTAMP_RECOGNIZER_TOP_DEFINES_SVH
`define RFC5424_TIMESTAMP_RECOGNIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define RTR_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("timestamp recognizer check failed");

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define RTR_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("timestamp recognizer check failed");

`endif

/* src/rtr_pkg.sv */
`default_nettype none

package rtr_pkg;

  // Parser phase codes: the element expected next.
  localparam logic [3:0] PH_YEAR  = 4'd0;
  localparam logic [3:0] PH_MONTH = 4'd1;
  localparam logic [3:0] PH_DAY   = 4'd2;
  localparam logic [3:0] PH_HOUR  = 4'd3;
  localparam logic [3:0] PH_MIN   = 4'd4;
  localparam logic [3:0] PH_SEC   = 4'd5;
  localparam logic [3:0] PH_FRAC  = 4'd6;
  localparam logic [3:0] PH_OFFH  = 4'd7;
  localparam logic [3:0] PH_OFFM  = 4'd8;
  localparam logic [3:0] PH_AFTER = 4'd9;

  // Transaction kinds.
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Characters of the timestamp grammar.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Field limits; digit runs saturate at VALUE_MAX.
  localparam logic [6:0] VALUE_MAX = 7'd127;
  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MIN_MAX   = 7'd59;
  localparam logic [6:0] SEC_MAX   = 7'd60;

  localparam int unsigned LENGTH_W = 16;

  // Parser control state.
  typedef struct packed {
    logic [3:0] phase;
    logic [6:0] value;
    logic       decided;
  } rtr_ctl_t;

  // Decision produced by one transaction.
  typedef struct packed {
    logic emit;
    logic matched;
  } rtr_res_t;

  localparam rtr_ctl_t CTL_RESET = '{phase: PH_YEAR, value: 7'd0, decided: 1'b0};

endpackage

`default_nettype wire

/* src/rtr_step.sv */
`default_nettype none

// Next-state and decision logic for one transaction of the parser.
module rtr_step import rtr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  rtr_ctl_t               ctl_i,
  input  logic [LENGTH_BITS-1:0] count_i,
  input  logic                   kind_i,
  input  logic [7:0]             ch_i,
  output rtr_ctl_t               ctl_o,
  output logic [LENGTH_BITS-1:0] count_o,
  output rtr_res_t               res_o
);

  logic                   is_digit;
  logic [10:0]            digit_acc;
  logic [6:0]             digit_sat;
  logic [LENGTH_BITS-1:0] count_inc;
  logic                   go_ok;
  logic [3:0]             go_phase;
  logic                   zone_ok;
  logic [3:0]             zone_phase;

  // Digit accumulation with saturation; the low nibble of an ASCII digit is its value.
  assign is_digit  = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign digit_acc = {4'd0, ctl_i.value} * 11'd10 + {7'd0, ch_i[3:0]};
  assign digit_sat = (digit_acc > {4'd0, VALUE_MAX}) ? VALUE_MAX : digit_acc[6:0];

  // Saturating byte counter.
  assign count_inc = (count_i == '1) ? count_i : count_i + 1'b1;

  // Time zone designator: Z closes the timestamp, a sign opens the offset.
  always_comb begin
    zone_ok    = 1'b0;
    zone_phase = PH_AFTER;
    if (ch_i == CH_Z) begin
      zone_ok = 1'b1;
    end else if (ch_i == CH_PLUS || ch_i == CH_DASH) begin
      zone_ok    = 1'b1;
      zone_phase = PH_OFFH;
    end
  end

  // Separator check for the current phase.
  always_comb begin
    go_ok    = 1'b0;
    go_phase = PH_AFTER;
    case (ctl_i.phase)
      PH_YEAR: begin
        go_ok    = (ch_i == CH_DASH);
        go_phase = PH_MONTH;
      end
      PH_MONTH: begin
        go_ok    = (ctl_i.value >= 7'd1) && (ctl_i.value <= MONTH_MAX) && (ch_i == CH_DASH);
        go_phase = PH_DAY;
      end
      PH_DAY: begin
        go_ok    = (ctl_i.value >= 7'd1) && (ctl_i.value <= DAY_MAX) && (ch_i == CH_T);
        go_phase = PH_HOUR;
      end
      PH_HOUR: begin
        go_ok    = (ctl_i.value <= HOUR_MAX) && (ch_i == CH_COLON);
        go_phase = PH_MIN;
      end
      PH_MIN: begin
        go_ok    = (ctl_i.value <= MIN_MAX) && (ch_i == CH_COLON);
        go_phase = PH_SEC;
      end
      PH_SEC: begin
        if (ctl_i.value <= SEC_MAX) begin
          if (ch_i == CH_DOT) begin
            go_ok    = 1'b1;
            go_phase = PH_FRAC;
          end else begin
            go_ok    = zone_ok;
            go_phase = zone_phase;
          end
        end
      end
      PH_FRAC: begin
        go_ok    = zone_ok;
        go_phase = zone_phase;
      end
      PH_OFFH: begin
        go_ok    = (ctl_i.value <= HOUR_MAX) && (ch_i == CH_COLON);
        go_phase = PH_OFFM;
      end
      default: begin
        go_ok = 1'b0;
      end
    endcase
  end

  // Transaction outcome.
  always_comb begin
    ctl_o       = ctl_i;
    count_o     = count_i;
    res_o       = '0;
    if (kind_i == KIND_END) begin
      // End of string: report if still undecided, then start over.
      ctl_o   = CTL_RESET;
      count_o = '0;
      if (!ctl_i.decided) begin
        res_o.emit    = 1'b1;
        res_o.matched = (ctl_i.phase == PH_AFTER) ||
                        (ctl_i.phase == PH_OFFM && ctl_i.value <= MIN_MAX);
      end
    end else if (ctl_i.decided) begin
      // Bytes after the decision are ignored.
    end else if (ctl_i.phase == PH_AFTER) begin
      res_o.emit    = 1'b1;
      res_o.matched = (ch_i == CH_SPACE);
      ctl_o.decided = 1'b1;
    end else if (ctl_i.phase > PH_AFTER) begin
      res_o.emit    = 1'b1;
      ctl_o.decided = 1'b1;
    end else if (is_digit) begin
      ctl_o.value = digit_sat;
      count_o     = count_inc;
    end else if (ctl_i.phase == PH_OFFM) begin
      // Offset minute is closed only by a space, which is not counted.
      res_o.emit    = 1'b1;
      res_o.matched = (ctl_i.value <= MIN_MAX) && (ch_i == CH_SPACE);
      ctl_o.decided = 1'b1;
    end else if (go_ok) begin
      ctl_o.phase = go_phase;
      ctl_o.value = 7'd0;
      count_o     = count_inc;
    end else begin
      res_o.emit    = 1'b1;
      ctl_o.decided = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* src/rfc5424_timestamp_recognizer_top.sv */
// Lenient RFC 5424 timestamp recognizer. Each input transaction carries one string byte
// (kind 0) or the end of the string (kind 1); one transaction is taken per clock cycle
// while in_stall_o is low. The block reports one result per string, on the transaction
// that decides it, registered when that transaction is accepted: matched, and the length
// of the timestamp (0 on a fail). The end transaction also clears the parser for the next
// string. Results pass through a two-entry output buffer, so in_stall_o rises only when
// two results are waiting; the per-byte decision is combinational over the parser state.
`default_nettype none

module rfc5424_timestamp_recognizer_top import rtr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [7:0]          ch_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                matched_o,
  output logic [LENGTH_W-1:0] length_o
);

  rtr_ctl_t               ctl_q, ctl_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  rtr_res_t               res;
  logic                   accept;
  logic                   push;
  logic                   pop;
  logic [LENGTH_W-1:0]    new_length;

  logic                   out_valid_q;
  logic                   out_matched_q;
  logic [LENGTH_W-1:0]    out_length_q;
  logic                   skid_valid_q;
  logic                   skid_matched_q;
  logic [LENGTH_W-1:0]    skid_length_q;

  rtr_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .ctl_i  (ctl_q),
    .count_i(count_q),
    .kind_i (kind_i),
    .ch_i   (ch_i),
    .ctl_o  (ctl_d),
    .count_o(count_d),
    .res_o  (res)
  );

  // Handshakes.
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && res.emit;
  assign pop        = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign new_length = res.matched ? LENGTH_W'(count_q) : '0;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_RESET;
      count_q <= '0;
    end else if (accept) begin
      ctl_q   <= ctl_d;
      count_q <= count_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_matched_q <= skid_matched_q;
        out_length_q  <= skid_length_q;
      end else if (push) begin
        out_matched_q <= res.matched;
        out_length_q  <= new_length;
      end
    end else if (push) begin
      skid_matched_q <= res.matched;
      skid_length_q  <= new_length;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = out_matched_q;
  assign length_o    = out_length_q;

endmodule

`default_nettype wire

/* src/rtr_checker.sv */
`default_nettype none
`include "rfc5424_timestamp_recognizer_top_defines.svh"

// Port-level checks on the timestamp recognizer.
module rtr_checker import rtr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                matched_o,
  input logic [LENGTH_W-1:0] length_o
);

  // A stalled result holds until it is taken.
  `RTR_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(matched_o) && $stable(length_o))

  // A fail always reports zero length.
  `RTR_ASSERT_IMP(a_fail_len, out_valid_o && !matched_o, length_o == '0)

  // Input back-pressure only while a result is waiting at the output.
  `RTR_ASSERT_IMP(a_stall_out, in_stall_o, out_valid_o)

  // Back-pressure follows a cycle in which the output was full and stalled.
  `RTR_ASSERT_IMP(a_stall_cause, in_stall_o, $past(out_valid_o && out_stall_i))

endmodule

bind rfc5424_timestamp_recognizer_top rtr_checker u_rtr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .matched_o  (matched_o),
  .length_o   (length_o)
);

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench import rtr_pkg::*;;

  localparam int unsigned COUNT_MAX   = (1 << LENGTH_W) - 1;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef logic [7:0] chars_t[$];

  typedef struct packed {
    logic                matched;
    logic [LENGTH_W-1:0] length;
  } ts_result_t;

  // Scoreboard: tracks the parser state and keeps the decisions still to come.
  class ts_scoreboard;
    ts_result_t  pending_q[$];
    int unsigned errors;
    logic [3:0]  phase;
    int unsigned value;
    int unsigned count;
    bit          decided;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase   = PH_YEAR;
      value   = 0;
      count   = 0;
      decided = 1'b0;
    endfunction

    function void bump();
      if (count < COUNT_MAX) count++;
    endfunction

    function void advance(logic [3:0] nxt);
      phase = nxt;
      value = 0;
      bump();
    endfunction

    function void decide(bit ok);
      ts_result_t r;
      decided   = 1'b1;
      r.matched = ok;
      r.length  = ok ? LENGTH_W'(count) : '0;
      pending_q.push_back(r);
    endfunction

    // Time zone designator after the seconds or the fraction.
    function bit zone_ok(logic [7:0] ch);
      if (ch == CH_Z) begin
        advance(PH_AFTER);
        return 1'b1;
      end
      if (ch == CH_PLUS || ch == CH_DASH) begin
        advance(PH_OFFH);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Notes an accepted transaction; returns 0 when the parser ignores it.
    function bit note_input(logic kind, logic [7:0] ch);
      int unsigned v;
      bit ok;
      if (kind == KIND_END) begin
        if (!decided)
          decide((phase == PH_AFTER) || (phase == PH_OFFM && value <= MIN_MAX));
        clear();
        return 1'b1;
      end
      if (decided) return 1'b0;
      if (phase == PH_AFTER) begin
        decide(ch == CH_SPACE);
        return 1'b1;
      end
      if (phase > PH_AFTER) begin
        decide(1'b0);
        return 1'b1;
      end
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        v = value * 10 + (ch - CH_ZERO);
        value = (v > VALUE_MAX) ? VALUE_MAX : v;
        bump();
        return 1'b1;
      end
      ok = 1'b0;
      case (phase)
        PH_YEAR: begin
          if (ch == CH_DASH) begin advance(PH_MONTH); ok = 1'b1; end
        end
        PH_MONTH: begin
          if (value >= 1 && value <= MONTH_MAX && ch == CH_DASH) begin
            advance(PH_DAY);
            ok = 1'b1;
          end
        end
        PH_DAY: begin
          if (value >= 1 && value <= DAY_MAX && ch == CH_T) begin
            advance(PH_HOUR);
            ok = 1'b1;
          end
        end
        PH_HOUR: begin
          if (value <= HOUR_MAX && ch == CH_COLON) begin advance(PH_MIN); ok = 1'b1; end
        end
        PH_MIN: begin
          if (value <= MIN_MAX && ch == CH_COLON) begin advance(PH_SEC); ok = 1'b1; end
        end
        PH_SEC: begin
          if (value <= SEC_MAX) begin
            if (ch == CH_DOT) begin
              advance(PH_FRAC);
              ok = 1'b1;
            end else begin
              ok = zone_ok(ch);
            end
          end
        end
        PH_FRAC: begin
          ok = zone_ok(ch);
        end
        PH_OFFH: begin
          if (value <= HOUR_MAX && ch == CH_COLON) begin advance(PH_OFFM); ok = 1'b1; end
        end
        PH_OFFM: begin
          if (value <= MIN_MAX && ch == CH_SPACE) begin
            decide(1'b1);
            return 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (!ok) decide(1'b0);
      return 1'b1;
    endfunction

    // Compares one output transaction with the oldest pending decision.
    function void check_result(logic matched, logic [LENGTH_W-1:0] length);
      ts_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: matched=%0b length=%0d", matched, length);
        return;
      end
      want = pending_q.pop_front();
      if (matched !== want.matched || length !== want.length) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected matched=%0b length=%0d, got matched=%0b length=%0d",
                   want.matched, want.length, matched, length);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                kind_i      = KIND_DATA;
  logic [7:0]          ch_i        = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                matched_o;
  logic [LENGTH_W-1:0] length_o;

  ts_scoreboard sb = new();
  int unsigned  cycle_count   = 0;
  int unsigned  in_idle_pct   = 0;
  int unsigned  out_stall_pct = 0;

  rfc5424_timestamp_recognizer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .matched_o   (matched_o),
    .length_o    (length_o)
  );

  always #6 clk_i = ~clk_i;

  // Cycle counter with a hard limit on the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls at random.
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < out_stall_pct);
  end

  // Every accepted output transaction is checked.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(matched_o, length_o);
  end

  // Drives one transaction, starting and ending at a falling edge.
  task automatic send_item(input logic kind, input logic [7:0] ch, output bit counted);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    ch_i       <= ch;
    do @(posedge clk_i); while (in_stall_o);
    counted = sb.note_input(kind, ch);
    @(negedge clk_i);
  endtask

  task automatic push_text(ref chars_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endtask

  // Sends a string and its end transaction; returns how many were not ignored.
  task automatic send_string(ref chars_t q, output int unsigned used);
    bit counted;
    used = 0;
    foreach (q[i]) begin
      send_item(KIND_DATA, q[i], counted);
      used += counted;
    end
    send_item(KIND_END, 8'($urandom_range(255)), counted);
    used += counted;
  endtask

  task automatic send_text(input string s);
    chars_t      q;
    int unsigned used;
    push_text(q, s);
    send_string(q, used);
  endtask

  // Appends a digit run: empty, at or just past the range edges, inside it, or any value up to 999.
  task automatic append_num(ref chars_t q, input int lo, input int hi);
    int sel;
    int val;
    sel = $urandom_range(9);
    if (sel == 0) return;
    case (sel)
      1: val = (lo > 0) ? lo - 1 : hi + 1;
      2: val = hi + 1;
      3: val = lo;
      4: val = hi;
      5: val = $urandom_range(999);
      default: val = $urandom_range(hi, lo);
    endcase
    if ($urandom_range(3) == 0) q.push_back(CH_ZERO);
    push_text(q, $sformatf("%0d", val));
  endtask

  task automatic append_noise(ref chars_t q, input int unsigned max_len);
    int unsigned n;
    n = $urandom_range(max_len);
    repeat (n) q.push_back(8'($urandom_range(255)));
  endtask

  // Builds a mostly well-formed timestamp with random content and a random tail.
  task automatic build_timestamp(ref chars_t q);
    int unsigned sel;
    if ($urandom_range(24) == 0) begin
      repeat ($urandom_range(400, 100)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end else begin
      append_num(q, 0, 9999);
    end
    q.push_back(CH_DASH);
    append_num(q, 1, MONTH_MAX);
    q.push_back(CH_DASH);
    append_num(q, 1, DAY_MAX);
    q.push_back(CH_T);
    append_num(q, 0, HOUR_MAX);
    q.push_back(CH_COLON);
    append_num(q, 0, MIN_MAX);
    q.push_back(CH_COLON);
    append_num(q, 0, SEC_MAX);
    if ($urandom_range(1) == 0) begin
      q.push_back(CH_DOT);
      repeat ($urandom_range(6)) q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    sel = $urandom_range(9);
    if (sel < 4) begin
      q.push_back(CH_Z);
    end else begin
      q.push_back((sel < 7) ? CH_PLUS : CH_DASH);
      append_num(q, 0, HOUR_MAX);
      q.push_back(CH_COLON);
      append_num(q, 0, MIN_MAX);
    end
    // Tail: a space and more text, nothing at all, or a random byte and more text.
    sel = $urandom_range(9);
    if (sel < 4) begin
      q.push_back(CH_SPACE);
      append_noise(q, 4);
    end else if (sel >= 7) begin
      q.push_back(8'($urandom_range(255)));
      append_noise(q, 4);
    end
    // Occasionally break the sequence by a corrupted or a cut-off byte.
    if (q.size() > 0 && $urandom_range(4) == 0) q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
    if (q.size() > 0 && $urandom_range(9) == 0) begin
      sel = $urandom_range(q.size() - 1);
      while (q.size() > sel) void'(q.pop_back());
    end
  endtask

  // Random strings until the target count of effective transactions is reached.
  task automatic run_strings(input int unsigned target);
    int unsigned done;
    int unsigned used;
    chars_t      q;
    done = 0;
    while (done < target) begin
      q.delete();
      if ($urandom_range(99) < 80) build_timestamp(q);
      else append_noise(q, 8);
      send_string(q, used);
      done += used;
    end
  endtask

  initial begin
    bit counted;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty string, bytes after a fail, trailing garbage, end in offset.
    send_item(KIND_END, 8'h00, counted);
    send_item(KIND_DATA, 8'hFF, counted);
    send_item(KIND_DATA, 8'h00, counted);
    send_item(KIND_END, 8'hFF, counted);
    send_text("-1-1T::Zx");
    send_text("-1-1T::-:");

    // Random part over the idling phases.
    in_idle_pct = 0;  out_stall_pct = 0;  run_strings(PHASE_ITEMS);
    in_idle_pct = 61; out_stall_pct = 0;  run_strings(PHASE_ITEMS);
    in_idle_pct = 0;  out_stall_pct = 61; run_strings(PHASE_ITEMS);
    in_idle_pct = 29; out_stall_pct = 29; run_strings(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* rfc5424_timestamp_recognizer_top.f */
+incdir+src
src/rtr_pkg.sv
src/rtr_step.sv
src/rfc5424_timestamp_recognizer_top.sv
src/rtr_checker.sv
test/testbench.sv
